[rtl/owb_pkg.sv]
`default_nettype none

package owb_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_WR_ONE   = 4'd4;
    localparam logic [3:0] PH_WR_SLOT  = 4'd5;
    localparam logic [3:0] PH_WR_REC   = 4'd6;
    localparam logic [3:0] PH_RD_LOW   = 4'd7;
    localparam logic [3:0] PH_RD_WAIT  = 4'd8;
    localparam logic [3:0] PH_RD_TAIL  = 4'd9;
    localparam logic [3:0] PH_RD_GAP   = 4'd10;

    // Configuration register indexes.
    localparam logic [2:0] REG_TICKS_PER_UNIT      = 3'd0;
    localparam logic [2:0] REG_RESET_LOW_UNITS     = 3'd1;
    localparam logic [2:0] REG_PRESENCE_WAIT_UNITS = 3'd2;
    localparam logic [2:0] REG_RESET_TAIL_UNITS    = 3'd3;
    localparam logic [2:0] REG_WRITE_SLOT_UNITS    = 3'd4;
    localparam logic [2:0] REG_READ_SAMPLE_UNITS   = 3'd5;
    localparam logic [2:0] REG_READ_TAIL_UNITS     = 3'd6;
    localparam logic [2:0] REG_READ_GAP_UNITS      = 3'd7;

    // Register values after reset.
    localparam logic [15:0] RST_TICKS_PER_UNIT      = 16'd120;
    localparam logic [7:0]  RST_RESET_LOW_UNITS     = 8'd50;
    localparam logic [7:0]  RST_PRESENCE_WAIT_UNITS = 8'd6;
    localparam logic [7:0]  RST_RESET_TAIL_UNITS    = 8'd42;
    localparam logic [7:0]  RST_WRITE_SLOT_UNITS    = 8'd10;
    localparam logic [7:0]  RST_READ_SAMPLE_UNITS   = 8'd1;
    localparam logic [7:0]  RST_READ_TAIL_UNITS     = 8'd4;
    localparam logic [7:0]  RST_READ_GAP_UNITS      = 8'd2;

    typedef struct packed {
        logic [15:0] ticks_per_unit;
        logic [7:0]  reset_low_units;
        logic [7:0]  presence_wait_units;
        logic [7:0]  reset_tail_units;
        logic [7:0]  write_slot_units;
        logic [7:0]  read_sample_units;
        logic [7:0]  read_tail_units;
        logic [7:0]  read_gap_units;
    } owb_cfg_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] tick_count;
        logic [7:0]  unit_count;
        logic [2:0]  bit_index;
        logic [7:0]  shift_byte;
        logic        presence_flag;
        logic        line_drive;
        logic [7:0]  last_read;
    } owb_state_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } owb_result_t;

endpackage

`default_nettype wire

[rtl/owb_cmd_if.sv]
`default_nettype none

interface owb_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic       line_level;

    modport source (output valid, output kind, output data, output line_level, input ready);
    modport sink (input valid, input kind, input data, input line_level, output ready);
endinterface

`default_nettype wire

[rtl/owb_res_if.sv]
`default_nettype none

interface owb_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, output rejected, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input presence, input read_data, input rejected, output ready);
endinterface

`default_nettype wire

[rtl/owb_cfg_if.sv]
`default_nettype none

interface owb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/owb_cfg_regs.sv]
`default_nettype none

module owb_cfg_regs (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire logic [2:0]      wr_index,
    input  wire logic [15:0]     wr_data,
    output owb_pkg::owb_cfg_t    cfg_regs
);
    import owb_pkg::*;

    owb_cfg_t cfg_reg;

    assign cfg_regs = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_unit      <= RST_TICKS_PER_UNIT;
            cfg_reg.reset_low_units     <= RST_RESET_LOW_UNITS;
            cfg_reg.presence_wait_units <= RST_PRESENCE_WAIT_UNITS;
            cfg_reg.reset_tail_units    <= RST_RESET_TAIL_UNITS;
            cfg_reg.write_slot_units    <= RST_WRITE_SLOT_UNITS;
            cfg_reg.read_sample_units   <= RST_READ_SAMPLE_UNITS;
            cfg_reg.read_tail_units     <= RST_READ_TAIL_UNITS;
            cfg_reg.read_gap_units      <= RST_READ_GAP_UNITS;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TICKS_PER_UNIT:      cfg_reg.ticks_per_unit      <= wr_data;
                REG_RESET_LOW_UNITS:     cfg_reg.reset_low_units     <= wr_data[7:0];
                REG_PRESENCE_WAIT_UNITS: cfg_reg.presence_wait_units <= wr_data[7:0];
                REG_RESET_TAIL_UNITS:    cfg_reg.reset_tail_units    <= wr_data[7:0];
                REG_WRITE_SLOT_UNITS:    cfg_reg.write_slot_units    <= wr_data[7:0];
                REG_READ_SAMPLE_UNITS:   cfg_reg.read_sample_units   <= wr_data[7:0];
                REG_READ_TAIL_UNITS:     cfg_reg.read_tail_units     <= wr_data[7:0];
                REG_READ_GAP_UNITS:      cfg_reg.read_gap_units      <= wr_data[7:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end
endmodule

`default_nettype wire

[rtl/owb_step.sv]
`default_nettype none

// Next-state and result logic of the bus sequencer for one item.
module owb_step (
    input  wire logic [1:0]      kind,
    input  wire logic [7:0]      data,
    input  wire logic            line_level,
    input  owb_pkg::owb_cfg_t    cfg_regs,
    input  owb_pkg::owb_state_t  state,
    output owb_pkg::owb_state_t  state_next,
    output owb_pkg::owb_result_t result
);
    import owb_pkg::*;

    // Zero-length waits that can follow the phase ended by a tick.
    localparam int ChainSteps = 3;

    typedef struct packed {
        owb_state_t st;
        logic       done;
    } work_t;

    function automatic logic is_wait(input logic [3:0] ph);
        return ph inside {PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_WR_SLOT,
                          PH_RD_WAIT, PH_RD_TAIL, PH_RD_GAP};
    endfunction

    function automatic logic [7:0] wait_units(input logic [3:0] ph, input owb_cfg_t c);
        logic [7:0] u;
        case (ph)
            PH_RST_LOW:  u = c.reset_low_units;
            PH_RST_WAIT: u = c.presence_wait_units;
            PH_RST_TAIL: u = c.reset_tail_units;
            PH_WR_SLOT:  u = c.write_slot_units;
            PH_RD_WAIT:  u = c.read_sample_units;
            PH_RD_TAIL:  u = c.read_tail_units;
            PH_RD_GAP:   u = c.read_gap_units;
            default:     u = 8'd0;
        endcase
        return u;
    endfunction

    function automatic owb_state_t enter(input owb_state_t s, input logic [3:0] ph,
                                         input logic drive);
        owb_state_t r;
        r = s;
        r.phase = ph;
        r.line_drive = drive;
        r.tick_count = 16'd0;
        r.unit_count = 8'd0;
        return r;
    endfunction

    function automatic owb_state_t start_write_bit(input owb_state_t s);
        owb_state_t r;
        if (s.shift_byte[s.bit_index])
            r = enter(s, PH_WR_ONE, 1'b1);
        else
            r = enter(s, PH_WR_SLOT, 1'b1);
        return r;
    endfunction

    function automatic work_t end_phase(input work_t w, input logic level);
        work_t r;
        r = w;
        case (w.st.phase)
            PH_RST_LOW:  r.st = enter(w.st, PH_RST_WAIT, 1'b0);
            PH_RST_WAIT:
            begin
                r.st.presence_flag = ~level;
                r.st = enter(r.st, PH_RST_TAIL, 1'b0);
            end
            PH_RST_TAIL:
            begin
                r.st = enter(w.st, PH_IDLE, 1'b0);
                r.done = 1'b1;
            end
            PH_WR_ONE:   r.st = enter(w.st, PH_WR_SLOT, 1'b0);
            PH_WR_SLOT:
            begin
                if (w.st.bit_index == 3'd7)
                begin
                    r.st = enter(w.st, PH_IDLE, 1'b0);
                    r.done = 1'b1;
                end
                else
                begin
                    r.st.bit_index = w.st.bit_index + 3'd1;
                    r.st = enter(r.st, PH_WR_REC, 1'b0);
                end
            end
            PH_WR_REC:   r.st = start_write_bit(w.st);
            PH_RD_LOW:   r.st = enter(w.st, PH_RD_WAIT, 1'b0);
            PH_RD_WAIT:
            begin
                if (level)
                    r.st.shift_byte[w.st.bit_index] = 1'b1;
                r.st = enter(r.st, PH_RD_TAIL, 1'b0);
            end
            PH_RD_TAIL:  r.st = enter(w.st, PH_RD_GAP, 1'b0);
            PH_RD_GAP:
            begin
                if (w.st.bit_index == 3'd7)
                begin
                    r.st.last_read = w.st.shift_byte;
                    r.st = enter(r.st, PH_IDLE, 1'b0);
                    r.done = 1'b1;
                end
                else
                begin
                    r.st.bit_index = w.st.bit_index + 3'd1;
                    r.st = enter(r.st, PH_RD_LOW, 1'b1);
                end
            end
            default:     r.st = enter(w.st, PH_IDLE, 1'b0);
        endcase
        return r;
    endfunction

    always_comb
    begin
        work_t       w;
        logic        rej;
        logic [7:0]  target;
        logic [15:0] tpu;
        logic [15:0] tick_inc;
        logic [7:0]  unit_inc;

        w.st = state;
        w.done = 1'b0;
        rej = 1'b0;
        target = wait_units(state.phase, cfg_regs);
        tpu = (cfg_regs.ticks_per_unit == 16'd0) ? 16'd1 : cfg_regs.ticks_per_unit;
        tick_inc = state.tick_count + 16'd1;
        unit_inc = state.unit_count + 8'd1;

        case (kind)
            KIND_TICK:
            begin
                if (state.phase != PH_IDLE)
                begin
                    if (!is_wait(state.phase) || target == 8'd0)
                        w = end_phase(w, line_level);
                    else if (tick_inc >= tpu)
                    begin
                        w.st.tick_count = 16'd0;
                        w.st.unit_count = unit_inc;
                        if (unit_inc >= target)
                            w = end_phase(w, line_level);
                    end
                    else
                        w.st.tick_count = tick_inc;

                    // Waits of zero units fall through on the same tick.
                    for (int i = 0; i < ChainSteps; i++)
                    begin
                        if (w.st.phase != PH_IDLE && is_wait(w.st.phase) &&
                            wait_units(w.st.phase, cfg_regs) == 8'd0)
                            w = end_phase(w, line_level);
                    end
                end
            end
            KIND_RESET:
            begin
                if (state.phase != PH_IDLE)
                    rej = 1'b1;
                else
                    w.st = enter(state, PH_RST_LOW, 1'b1);
            end
            KIND_WRITE:
            begin
                if (state.phase != PH_IDLE)
                    rej = 1'b1;
                else
                begin
                    w.st.shift_byte = data;
                    w.st.bit_index = 3'd0;
                    w.st = start_write_bit(w.st);
                end
            end
            KIND_READ:
            begin
                if (state.phase != PH_IDLE)
                    rej = 1'b1;
                else
                begin
                    w.st.shift_byte = 8'd0;
                    w.st.bit_index = 3'd0;
                    w.st = enter(w.st, PH_RD_LOW, 1'b1);
                end
            end
            default:
            begin
                rej = 1'b0;
            end
        endcase

        state_next = w.st;
        result.drive_low = w.st.line_drive;
        result.busy_res = (w.st.phase != PH_IDLE);
        result.done_res = w.done;
        result.presence = w.st.presence_flag;
        result.read_data = w.st.last_read;
        result.rejected = rej;
    end
endmodule

`default_nettype wire

[rtl/one_wire_bus_master.sv]
// 1-Wire bus master. Each request on the cmd channel is either a timer tick carrying the
// sampled bus level or a command (bus reset with presence detect, write byte, read byte),
// and each one yields exactly one result on the res channel telling whether the line is to
// be pulled low, whether a command is running, whether it finished on this request, the
// last presence answer, the last byte read, and whether a command was rejected because
// the bus was busy. All waits count delay units of ticks_per_unit ticks, set through the
// cfg channel, which should only be written while no command runs. The block accepts one
// request every clock cycle while results are taken; a request is held in the input
// register and its result is then registered in the output register. That rate is set
// by the single-pass sequencer logic between those two registers, which also resolves
// any chain of zero-length waits within the same cycle.
`default_nettype none

module one_wire_bus_master (
    input  wire logic clk,
    input  wire logic rst_n,
    owb_cmd_if.sink   cmd,
    owb_res_if.source res,
    owb_cfg_if.sink   cfg
);
    import owb_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [1:0] in_kind_reg;
    logic [7:0] in_data_reg;
    logic       in_level_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    owb_result_t out_reg;

    // Sequencer state.
    owb_state_t state_reg;
    owb_state_t state_next;

    owb_cfg_t    cfg_regs;
    owb_result_t step_result;

    logic cmd_accept;
    logic advance;
    logic fire;

    // The result register frees up when it is empty or being taken this cycle, and the
    // input register can then hand its request on. A new request is taken whenever the
    // input register is empty or is emptying, so a stalled result never blocks a cycle
    // more than it must.
    assign advance    = !out_valid_reg || res.ready;
    assign fire       = in_valid_reg && advance;
    assign cmd.ready  = !in_valid_reg || fire;
    assign cmd_accept = cmd.valid && cmd.ready;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    owb_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.wdata),
        .cfg_regs (cfg_regs)
    );

    owb_step u_step (
        .kind       (in_kind_reg),
        .data       (in_data_reg),
        .line_level (in_level_reg),
        .cfg_regs   (cfg_regs),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    // Control state: the sequencer only moves when a request passes into the result
    // register, so a stalled output also freezes the bus timing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            in_kind_reg  <= cmd.kind;
            in_data_reg  <= cmd.data;
            in_level_reg <= cmd.line_level;
        end
        if (fire)
            out_reg <= step_result;
    end

    assign res.valid     = out_valid_reg;
    assign res.drive_low = out_reg.drive_low;
    assign res.busy_res  = out_reg.busy_res;
    assign res.done_res  = out_reg.done_res;
    assign res.presence  = out_reg.presence;
    assign res.read_data = out_reg.read_data;
    assign res.rejected  = out_reg.rejected;
endmodule

`default_nettype wire

[rtl/owb_checker.sv]
`default_nettype none

module owb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       drive_low,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic       presence,
    input wire logic [7:0] read_data,
    input wire logic       rejected
);
    // A stalled result keeps its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
        $stable({drive_low, busy_res, done_res, presence, read_data, rejected}))
        else $error("result changed while stalled");

    // A finished command leaves the sequencer idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !busy_res && !drive_low)
        else $error("done reported while still busy");

    // Only a busy sequencer rejects, and a rejected command finishes nothing.
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && rejected |-> busy_res && !done_res)
        else $error("command rejected while idle");

    // The line is only pulled low during a command.
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && drive_low |-> busy_res)
        else $error("line driven low while idle");
endmodule

bind one_wire_bus_master owb_checker u_owb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .drive_low (res.drive_low),
    .busy_res  (res.busy_res),
    .done_res  (res.done_res),
    .presence  (res.presence),
    .read_data (res.read_data),
    .rejected  (res.rejected)
);

`default_nettype wire
